@@ design/ctcl_pkg.sv @@
// Shared types, codes and helpers of the text console cursor controller.
package ctcl_pkg;

	localparam int GLYPH_HEIGHT_DEF = 16;
	localparam int MAX_SCREEN_DEF   = 4096;

	localparam int DIM_W        = 14;
	localparam int POS_W        = 13;
	localparam int CODE_W       = 21;
	localparam int GW_W         = 5;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 13;
	localparam int CELL_W       = 8;
	localparam int MIN_DIM      = 16;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [POS_W-1:0] WIDTH_RST  = 13'd1024;
	localparam logic [POS_W-1:0] HEIGHT_RST = 13'd768;

	localparam logic [CODE_W-1:0] LF_CODE   = 21'd10;
	localparam logic [CODE_W-1:0] CR_CODE   = 21'd13;
	localparam logic [GW_W-1:0]   GLYPH_MAX = 5'd16;

	localparam logic [1:0] MODE_CHAR = 2'd0;
	localparam logic [1:0] MODE_BS   = 2'd1;
	localparam logic [1:0] MODE_CLS  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS = 2'd2;

	typedef enum logic [1:0] {
		ACT_DRAW   = 2'd0,
		ACT_CELL   = 2'd1,
		ACT_SCROLL = 2'd2,
		ACT_CLS    = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		OP_DRAW = 3'd0,
		OP_LF   = 3'd1,
		OP_CR   = 3'd2,
		OP_BS   = 3'd3,
		OP_CLS  = 3'd4
	} op_kind_t;

	typedef struct packed {
		op_kind_t            kind;
		logic [CODE_W-1:0]   code;
		logic [GW_W-1:0]     gw;
	} op_t;

	typedef struct packed {
		act_t                action;
		logic [POS_W-1:0]    pos_x;
		logic [POS_W-1:0]    pos_y;
		logic [CODE_W-1:0]   glyph_code;
		logic [GW_W-1:0]     draw_width;
		logic                last;
	} res_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [POS_W-1:0] v,
			input logic [DIM_W-1:0] max_dim);
		logic [DIM_W-1:0] ext;
		ext = {1'b0, v};
		if (ext < DIM_W'(MIN_DIM)) begin
			return DIM_W'(MIN_DIM);
		end
		if (ext > max_dim) begin
			return max_dim;
		end
		return ext;
	endfunction

endpackage

@@ design/ctcl_if.sv @@
// Event and command channel interfaces of the text console cursor controller.
interface ctcl_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [20:0] code_point;
	logic [4:0]  glyph_width;

	modport source(output valid, output mode, output code_point, output glyph_width,
		input ready);
	modport sink(input valid, input mode, input code_point, input glyph_width,
		output ready);
endinterface

interface ctcl_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [12:0] pos_x;
	logic [12:0] pos_y;
	logic [20:0] glyph_code;
	logic [4:0]  draw_width;
	logic        last;

	modport source(output valid, output action, output pos_x, output pos_y,
		output glyph_code, output draw_width, output last, input ready);
	modport sink(input valid, input action, input pos_x, input pos_y,
		input glyph_code, input draw_width, input last, output ready);
endinterface

@@ design/ctcl_front.sv @@
// Front stage: accept events, classify them and drop those without effect.
module ctcl_front (
	input  logic             clk,
	input  logic             arst_n,
	ctcl_evt_if.sink         evt,
	input  logic             suppress,
	output logic             push_valid,
	output ctcl_pkg::op_t    push_op,
	input  logic             push_ready
);

	logic          valid_s1;
	ctcl_pkg::op_t op_s1;
	ctcl_pkg::op_t cls_op;
	logic          keep;

	assign evt.ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_op    = op_s1;

	always_comb begin
		cls_op.code = evt.code_point;
		cls_op.gw   = (evt.glyph_width > ctcl_pkg::GLYPH_MAX) ? ctcl_pkg::GLYPH_MAX
			: evt.glyph_width;
		cls_op.kind = ctcl_pkg::OP_DRAW;
		keep        = 1'b0;
		case (evt.mode)
			ctcl_pkg::MODE_CHAR: begin
				keep = !suppress;
				if (evt.code_point == ctcl_pkg::LF_CODE) begin
					cls_op.kind = ctcl_pkg::OP_LF;
				end else if (evt.code_point == ctcl_pkg::CR_CODE) begin
					cls_op.kind = ctcl_pkg::OP_CR;
				end else begin
					cls_op.kind = ctcl_pkg::OP_DRAW;
				end
			end
			ctcl_pkg::MODE_BS: begin
				keep        = !suppress;
				cls_op.kind = ctcl_pkg::OP_BS;
			end
			ctcl_pkg::MODE_CLS: begin
				keep        = 1'b1;
				cls_op.kind = ctcl_pkg::OP_CLS;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			op_s1 <= cls_op;
		end
	end

endmodule

@@ design/ctcl_queue.sv @@
// Short request queue between the classifying front and the cursor back end.
module ctcl_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  ctcl_pkg::op_t    push_op,
	output logic             push_ready,
	output logic             pop_valid,
	output ctcl_pkg::op_t    pop_op,
	input  logic             pop_ready
);

	localparam int PTR_W = (ctcl_pkg::QUEUE_DEPTH > 1) ? $clog2(ctcl_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(ctcl_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ctcl_pkg::QUEUE_DEPTH - 1);

	ctcl_pkg::op_t    slot_q [ctcl_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = cnt_q < CNT_W'(ctcl_pkg::QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_op     = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

@@ design/ctcl_back.sv @@
// Back end: keep the cursor, carry out requests and issue draw commands.
module ctcl_back #(
	parameter int GLYPH_HEIGHT = ctcl_pkg::GLYPH_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pop_valid,
	input  ctcl_pkg::op_t                pop_op,
	output logic                         pop_ready,
	input  logic [ctcl_pkg::DIM_W-1:0]   scr_w,
	input  logic [ctcl_pkg::DIM_W-1:0]   scr_h,
	ctcl_cmd_if.source                   cmd
);

	localparam int PW = ctcl_pkg::POS_W;
	localparam int DW = ctcl_pkg::DIM_W;
	localparam logic [PW-1:0] GH_P   = PW'(GLYPH_HEIGHT);
	localparam logic [DW-1:0] GH_D   = DW'(GLYPH_HEIGHT);
	localparam logic [PW-1:0] CELL_P = PW'(ctcl_pkg::CELL_W);
	localparam logic [DW-1:0] CELL_D = DW'(ctcl_pkg::CELL_W);

	logic [PW-1:0]  cx_q;
	logic [PW-1:0]  cy_q;
	logic           out_valid_q;
	ctcl_pkg::res_t out_q;
	logic           pend_valid_q;
	ctcl_pkg::res_t pend_q;

	logic [PW-1:0]  ny;
	logic           scroll_need;
	logic [PW-1:0]  nl_y;
	logic           no_fit;
	logic [PW-1:0]  cx_n;
	logic [PW-1:0]  cy_n;
	logic [PW-1:0]  draw_x;
	logic [PW-1:0]  draw_y;
	ctcl_pkg::res_t res_a;
	ctcl_pkg::res_t res_b;
	logic [1:0]     res_cnt;
	logic           adv;
	logic           pop_fire;

	assign adv       = !out_valid_q || cmd.ready;
	assign pop_ready = !pend_valid_q && adv;
	assign pop_fire  = pop_valid && pop_ready;

	assign ny          = cy_q + GH_P;
	assign scroll_need = ({1'b0, ny} + GH_D) > scr_h;
	assign nl_y        = scroll_need ? cy_q : ny;
	assign no_fit      = ({1'b0, cx_q} + {{(DW-ctcl_pkg::GW_W){1'b0}}, pop_op.gw}) > scr_w;
	assign draw_x      = no_fit ? '0 : cx_q;
	assign draw_y      = no_fit ? nl_y : cy_q;

	always_comb begin
		cx_n    = cx_q;
		cy_n    = cy_q;
		res_cnt = 2'd0;
		res_a   = '0;
		res_b   = '0;
		case (pop_op.kind)
			ctcl_pkg::OP_DRAW: begin
				cx_n = draw_x + {{(PW-ctcl_pkg::GW_W){1'b0}}, pop_op.gw};
				cy_n = draw_y;
				if (no_fit && scroll_need) begin
					res_cnt           = 2'd2;
					res_a.action      = ctcl_pkg::ACT_SCROLL;
					res_b.action      = ctcl_pkg::ACT_DRAW;
					res_b.pos_x       = draw_x;
					res_b.pos_y       = draw_y;
					res_b.glyph_code  = pop_op.code;
					res_b.draw_width  = pop_op.gw;
					res_b.last        = 1'b1;
				end else begin
					res_cnt           = 2'd1;
					res_a.action      = ctcl_pkg::ACT_DRAW;
					res_a.pos_x       = draw_x;
					res_a.pos_y       = draw_y;
					res_a.glyph_code  = pop_op.code;
					res_a.draw_width  = pop_op.gw;
					res_a.last        = 1'b1;
				end
			end
			ctcl_pkg::OP_LF: begin
				cx_n = '0;
				cy_n = nl_y;
				if (scroll_need) begin
					res_cnt      = 2'd1;
					res_a.action = ctcl_pkg::ACT_SCROLL;
					res_a.last   = 1'b1;
				end
			end
			ctcl_pkg::OP_CR: begin
				cx_n = '0;
			end
			ctcl_pkg::OP_BS: begin
				if (cx_q >= CELL_P) begin
					cx_n = cx_q - CELL_P;
					res_cnt = 2'd1;
				end else if (cy_q >= GH_P) begin
					cy_n = cy_q - GH_P;
					cx_n = PW'(scr_w - CELL_D);
					res_cnt = 2'd1;
				end
				res_a.action     = ctcl_pkg::ACT_CELL;
				res_a.pos_x      = cx_n;
				res_a.pos_y      = cy_n;
				res_a.draw_width = ctcl_pkg::GW_W'(ctcl_pkg::CELL_W);
				res_a.last       = 1'b1;
			end
			ctcl_pkg::OP_CLS: begin
				cx_n         = '0;
				cy_n         = '0;
				res_cnt      = 2'd1;
				res_a.action = ctcl_pkg::ACT_CLS;
				res_a.last   = 1'b1;
			end
			default: begin
				res_cnt = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q         <= '0;
			cy_q         <= '0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (pop_fire) begin
				cx_q <= cx_n;
				cy_q <= cy_n;
			end
			if (pop_fire && res_cnt != 2'd0) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= res_cnt == 2'd2;
			end else if (pend_valid_q && adv) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (adv) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_fire && res_cnt != 2'd0) begin
			out_q  <= res_a;
			pend_q <= res_b;
		end else if (pend_valid_q && adv) begin
			out_q  <= pend_q;
		end
	end

	assign cmd.valid      = out_valid_q;
	assign cmd.action     = out_q.action;
	assign cmd.pos_x      = out_q.pos_x;
	assign cmd.pos_y      = out_q.pos_y;
	assign cmd.glyph_code = out_q.glyph_code;
	assign cmd.draw_width = out_q.draw_width;
	assign cmd.last       = out_q.last;

endmodule

@@ design/text_console_cursor_layout_top.sv @@
// Text console cursor controller: configuration registers, front, queue and back end.
//
// Events enter on the evt channel (valid/ready): mode, code point and glyph width.
// Draw commands leave on the cmd channel (valid/ready): action, position, code,
// width and a last flag on the final command of each event.
// Screen width, height and suppress are written through cfg_we/cfg_idx/cfg_wdata;
// the user must write them only while no event is in flight; the block itself
// does not enforce this. Width and height are clamped on write.
// While evt.ready stays high, one event is taken per cycle. An event that wraps
// and scrolls yields two commands and holds the back end while the second waits
// in the pending slot; while cmd.ready is high the command register sets the rate
// at one command per cycle. Carriage returns and plain line feeds yield no command
// but pass through the queue to the back end; suppressed events and unknown modes
// are dropped in the front stage.
// When cmd.ready is low the command register and a one-entry pending slot hold,
// the two-entry queue and the front stage fill, and evt.ready then drops.
// Reset clears the cursor to the top-left corner, empties the pipeline and
// loads width 1024, height 768 and suppress 0.
module text_console_cursor_layout_top #(
	parameter int GLYPH_HEIGHT = ctcl_pkg::GLYPH_HEIGHT_DEF,
	parameter int MAX_SCREEN   = ctcl_pkg::MAX_SCREEN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ctcl_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [ctcl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	ctcl_evt_if.sink                          evt,
	ctcl_cmd_if.source                        cmd
);

	localparam logic [ctcl_pkg::DIM_W-1:0] MAX_D = ctcl_pkg::DIM_W'(MAX_SCREEN);
	localparam logic [ctcl_pkg::DIM_W-1:0] W_RST =
		ctcl_pkg::clamp_dim(ctcl_pkg::WIDTH_RST, MAX_D);
	localparam logic [ctcl_pkg::DIM_W-1:0] H_RST =
		ctcl_pkg::clamp_dim(ctcl_pkg::HEIGHT_RST, MAX_D);

	logic [ctcl_pkg::DIM_W-1:0] scr_w_q;
	logic [ctcl_pkg::DIM_W-1:0] scr_h_q;
	logic                       suppress_q;

	logic          push_valid;
	ctcl_pkg::op_t push_op;
	logic          push_ready;
	logic          pop_valid;
	ctcl_pkg::op_t pop_op;
	logic          pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q    <= W_RST;
			scr_h_q    <= H_RST;
			suppress_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				ctcl_pkg::CFG_WIDTH: begin
					scr_w_q <= ctcl_pkg::clamp_dim(cfg_wdata, MAX_D);
				end
				ctcl_pkg::CFG_HEIGHT: begin
					scr_h_q <= ctcl_pkg::clamp_dim(cfg_wdata, MAX_D);
				end
				ctcl_pkg::CFG_SUPPRESS: begin
					suppress_q <= cfg_wdata[0];
				end
				default: begin
					suppress_q <= suppress_q;
				end
			endcase
		end
	end

	ctcl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt        (evt),
		.suppress   (suppress_q),
		.push_valid (push_valid),
		.push_op    (push_op),
		.push_ready (push_ready)
	);

	ctcl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_op    (push_op),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_op     (pop_op),
		.pop_ready  (pop_ready)
	);

	ctcl_back #(
		.GLYPH_HEIGHT (GLYPH_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_op     (pop_op),
		.pop_ready  (pop_ready),
		.scr_w      (scr_w_q),
		.scr_h      (scr_h_q),
		.cmd        (cmd)
	);

endmodule

@@ dv/tb_text_console_cursor_layout_top.sv @@
// Self-checking testbench of the text console cursor controller: directed table, then random phases.
`timescale 1ns / 1ps

module tb_text_console_cursor_layout_top;
	import ctcl_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 16;
	localparam res_t NO_CMD = '0;

	typedef struct packed {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		logic [1:0]            mode;
		logic [CODE_W-1:0]     cp;
		logic [GW_W-1:0]       gw;
		logic                  typed;
		logic [1:0]            n_typed;
		res_t                  t0;
		res_t                  t1;
	} step_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ctcl_evt_if evt_bus ();
	ctcl_cmd_if cmd_bus ();

	text_console_cursor_layout_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.evt      (evt_bus),
		.cmd      (cmd_bus)
	);

	logic [POS_W-1:0] scr_width;
	logic [POS_W-1:0] scr_height;
	logic             scr_suppress;
	logic [POS_W-1:0] cur_x;
	logic [POS_W-1:0] cur_y;

	res_t  pending_cmds [$];
	res_t  predicted_cmds [$];
	step_t plan [$];
	res_t  seen_cmd;
	res_t  want_cmd;
	int    errors;
	int    gap_pct;
	int    stall_pct;

	always #5 clk = ~clk;

	function automatic int fit_dim(input logic [POS_W-1:0] v);
		if (v < MIN_DIM) begin
			return MIN_DIM;
		end
		if (v > MAX_SCREEN_DEF) begin
			return MAX_SCREEN_DEF;
		end
		return int'(v);
	endfunction

	function automatic res_t mk_cmd(input act_t a, input int x, input int y, input int code,
			input int w, input logic l);
		res_t r;
		r.action     = a;
		r.pos_x      = POS_W'(x);
		r.pos_y      = POS_W'(y);
		r.glyph_code = CODE_W'(code);
		r.draw_width = GW_W'(w);
		r.last       = l;
		return r;
	endfunction

	function automatic logic line_feed_scrolls(input int h);
		cur_x = '0;
		cur_y = cur_y + POS_W'(GLYPH_HEIGHT_DEF);
		if (int'(cur_y) + GLYPH_HEIGHT_DEF > h) begin
			cur_y = cur_y - POS_W'(GLYPH_HEIGHT_DEF);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void predict_commands(input logic [1:0] mode, input logic [CODE_W-1:0] cp,
			input logic [GW_W-1:0] gw_in);
		int w;
		int h;
		int gw;
		w  = fit_dim(scr_width);
		h  = fit_dim(scr_height);
		gw = (gw_in > GLYPH_MAX) ? int'(GLYPH_MAX) : int'(gw_in);
		predicted_cmds.delete();
		case (mode)
			MODE_CHAR: begin
				if (!scr_suppress) begin
					if (cp == LF_CODE) begin
						if (line_feed_scrolls(h)) begin
							predicted_cmds.push_back(mk_cmd(ACT_SCROLL, 0, 0, 0, 0, 1'b1));
						end
					end else if (cp == CR_CODE) begin
						cur_x = '0;
					end else begin
						if (int'(cur_x) + gw > w) begin
							if (line_feed_scrolls(h)) begin
								predicted_cmds.push_back(mk_cmd(ACT_SCROLL, 0, 0, 0, 0, 1'b0));
							end
						end
						predicted_cmds.push_back(mk_cmd(ACT_DRAW, int'(cur_x), int'(cur_y),
							int'(cp), gw, 1'b1));
						cur_x = cur_x + POS_W'(gw);
					end
				end
			end
			MODE_BS: begin
				if (!scr_suppress) begin
					if (cur_x >= CELL_W) begin
						cur_x = cur_x - POS_W'(CELL_W);
						predicted_cmds.push_back(mk_cmd(ACT_CELL, int'(cur_x), int'(cur_y), 0,
							CELL_W, 1'b1));
					end else if (cur_y >= GLYPH_HEIGHT_DEF) begin
						cur_y = cur_y - POS_W'(GLYPH_HEIGHT_DEF);
						cur_x = POS_W'(w - CELL_W);
						predicted_cmds.push_back(mk_cmd(ACT_CELL, int'(cur_x), int'(cur_y), 0,
							CELL_W, 1'b1));
					end
				end
			end
			MODE_CLS: begin
				cur_x = '0;
				cur_y = '0;
				predicted_cmds.push_back(mk_cmd(ACT_CLS, 0, 0, 0, 0, 1'b1));
			end
			default: begin
			end
		endcase
	endfunction

	function automatic step_t ev_row(input logic [1:0] m, input int cp, input int gw);
		step_t s;
		s      = '0;
		s.mode = m;
		s.cp   = CODE_W'(cp);
		s.gw   = GW_W'(gw);
		return s;
	endfunction

	function automatic step_t ev_typed(input logic [1:0] m, input int cp, input int gw,
			input int n, input res_t r0, input res_t r1);
		step_t s;
		s         = ev_row(m, cp, gw);
		s.typed   = 1'b1;
		s.n_typed = 2'(n);
		s.t0      = r0;
		s.t1      = r1;
		return s;
	endfunction

	function automatic step_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
		step_t s;
		s        = '0;
		s.is_cfg = 1'b1;
		s.idx    = idx;
		s.val    = CFG_DATA_W'(val);
		return s;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_WIDTH:    scr_width = val;
			CFG_HEIGHT:   scr_height = val;
			CFG_SUPPRESS: scr_suppress = val[0];
			default: begin
			end
		endcase
	endtask

	task automatic issue_event(input logic [1:0] m, input logic [CODE_W-1:0] cp,
			input logic [GW_W-1:0] gw);
		int n_gap;
		n_gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 6) : 0;
		repeat (n_gap) begin
			@(negedge clk);
			evt_bus.valid <= 1'b0;
		end
		@(negedge clk);
		evt_bus.valid       <= 1'b1;
		evt_bus.mode        <= m;
		evt_bus.code_point  <= cp;
		evt_bus.glyph_width <= gw;
		@(posedge clk);
		while (!evt_bus.ready) begin
			@(posedge clk);
		end
	endtask

	task automatic settle();
		@(negedge clk);
		evt_bus.valid <= 1'b0;
		while (pending_cmds.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic make_event(output logic [1:0] m, output logic [CODE_W-1:0] cp,
			output logic [GW_W-1:0] gw);
		int r;
		r  = $urandom_range(99);
		gw = ($urandom_range(99) < 85) ? GW_W'($urandom_range(0, 16)) : GW_W'($urandom_range(17, 31));
		if (r < 55) begin
			m  = MODE_CHAR;
			cp = ($urandom_range(99) < 70) ? CODE_W'($urandom_range(32, 126))
				: CODE_W'($urandom_range(0, 2097151));
		end else if (r < 67) begin
			m  = MODE_CHAR;
			cp = LF_CODE;
		end else if (r < 72) begin
			m  = MODE_CHAR;
			cp = CR_CODE;
		end else if (r < 88) begin
			m  = MODE_BS;
			cp = CODE_W'($urandom_range(0, 2097151));
		end else if (r < 91) begin
			m  = MODE_CLS;
			cp = CODE_W'($urandom_range(0, 2097151));
		end else if (r < 94) begin
			m  = MODE_UNUSED;
			cp = CODE_W'($urandom_range(0, 2097151));
		end else begin
			m  = 2'($urandom_range(0, 3));
			cp = CODE_W'($urandom_range(0, 2097151));
			gw = GW_W'($urandom_range(0, 31));
		end
	endtask

	always @(negedge clk) begin
		cmd_bus.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && cmd_bus.valid && cmd_bus.ready) begin
			seen_cmd.action     = act_t'(cmd_bus.action);
			seen_cmd.pos_x      = cmd_bus.pos_x;
			seen_cmd.pos_y      = cmd_bus.pos_y;
			seen_cmd.glyph_code = cmd_bus.glyph_code;
			seen_cmd.draw_width = cmd_bus.draw_width;
			seen_cmd.last       = cmd_bus.last;
			if (pending_cmds.size() == 0) begin
				$display("%0t unexpected command: act=%0d x=%0d y=%0d code=%0h w=%0d last=%0d",
					$time, seen_cmd.action, seen_cmd.pos_x, seen_cmd.pos_y,
					seen_cmd.glyph_code, seen_cmd.draw_width, seen_cmd.last);
				errors++;
			end else begin
				want_cmd = pending_cmds.pop_front();
				if (seen_cmd !== want_cmd) begin
					$display("%0t expected act=%0d x=%0d y=%0d code=%0h w=%0d last=%0d",
						$time, want_cmd.action, want_cmd.pos_x, want_cmd.pos_y,
						want_cmd.glyph_code, want_cmd.draw_width, want_cmd.last);
					$display("%0t actual   act=%0d x=%0d y=%0d code=%0h w=%0d last=%0d",
						$time, seen_cmd.action, seen_cmd.pos_x, seen_cmd.pos_y,
						seen_cmd.glyph_code, seen_cmd.draw_width, seen_cmd.last);
					errors++;
				end
			end
		end
	end

	initial begin
		#5000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [1:0]        m;
		logic [CODE_W-1:0] cp;
		logic [GW_W-1:0]   gw;
		step_t             s;
		int                n_items;
		clk                 = 1'b0;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_idx             = '0;
		cfg_wdata           = '0;
		evt_bus.valid       = 1'b0;
		evt_bus.mode        = '0;
		evt_bus.code_point  = '0;
		evt_bus.glyph_width = '0;
		cmd_bus.ready       = 1'b0;
		errors              = 0;
		gap_pct             = 0;
		stall_pct           = 0;
		scr_width           = WIDTH_RST;
		scr_height          = HEIGHT_RST;
		scr_suppress        = 1'b0;
		cur_x               = '0;
		cur_y               = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		plan.push_back(ev_typed(MODE_BS, 0, 0, 0, NO_CMD, NO_CMD));
		plan.push_back(ev_typed(MODE_CHAR, 65, 8, 1, mk_cmd(ACT_DRAW, 0, 0, 65, 8, 1'b1), NO_CMD));
		plan.push_back(ev_typed(MODE_CHAR, 2097151, 31, 1,
			mk_cmd(ACT_DRAW, 8, 0, 2097151, 16, 1'b1), NO_CMD));
		plan.push_back(ev_typed(MODE_CHAR, int'(CR_CODE), 7, 0, NO_CMD, NO_CMD));
		plan.push_back(ev_typed(MODE_CHAR, 0, 0, 1, mk_cmd(ACT_DRAW, 0, 0, 0, 0, 1'b1), NO_CMD));
		plan.push_back(ev_typed(MODE_CHAR, int'(LF_CODE), 31, 0, NO_CMD, NO_CMD));
		plan.push_back(ev_typed(MODE_BS, 0, 0, 1, mk_cmd(ACT_CELL, 1016, 0, 0, 8, 1'b1), NO_CMD));
		plan.push_back(ev_typed(MODE_BS, 0, 0, 1, mk_cmd(ACT_CELL, 1008, 0, 0, 8, 1'b1), NO_CMD));
		plan.push_back(ev_typed(MODE_UNUSED, int'(LF_CODE), 5, 0, NO_CMD, NO_CMD));
		plan.push_back(ev_typed(MODE_CLS, 0, 0, 1, mk_cmd(ACT_CLS, 0, 0, 0, 0, 1'b1), NO_CMD));
		plan.push_back(cfg_row(CFG_WIDTH, 0));
		plan.push_back(cfg_row(CFG_HEIGHT, 0));
		plan.push_back(ev_typed(MODE_CHAR, 66, 16, 1, mk_cmd(ACT_DRAW, 0, 0, 66, 16, 1'b1), NO_CMD));
		plan.push_back(ev_typed(MODE_CHAR, 67, 1, 2, mk_cmd(ACT_SCROLL, 0, 0, 0, 0, 1'b0),
			mk_cmd(ACT_DRAW, 0, 0, 67, 1, 1'b1)));
		plan.push_back(ev_typed(MODE_CHAR, int'(LF_CODE), 0, 1,
			mk_cmd(ACT_SCROLL, 0, 0, 0, 0, 1'b1), NO_CMD));
		plan.push_back(ev_typed(MODE_BS, 0, 0, 0, NO_CMD, NO_CMD));
		plan.push_back(ev_row(MODE_CHAR, 68, 9));
		plan.push_back(ev_row(MODE_BS, 0, 0));
		plan.push_back(ev_row(MODE_CHAR, 69, 20));
		plan.push_back(cfg_row(CFG_SUPPRESS, 1));
		plan.push_back(ev_typed(MODE_CHAR, 70, 8, 0, NO_CMD, NO_CMD));
		plan.push_back(ev_typed(MODE_BS, 0, 0, 0, NO_CMD, NO_CMD));
		plan.push_back(ev_typed(MODE_CHAR, int'(LF_CODE), 0, 0, NO_CMD, NO_CMD));
		plan.push_back(ev_typed(MODE_CLS, 0, 0, 1, mk_cmd(ACT_CLS, 0, 0, 0, 0, 1'b1), NO_CMD));
		plan.push_back(cfg_row(CFG_SUPPRESS, 0));
		plan.push_back(cfg_row(CFG_WIDTH, 8191));
		plan.push_back(cfg_row(CFG_HEIGHT, 8191));
		plan.push_back(ev_row(MODE_CHAR, 71, 16));
		plan.push_back(ev_row(MODE_CHAR, int'(LF_CODE), 0));

		foreach (plan[i]) begin
			s = plan[i];
			if (s.is_cfg) begin
				settle();
				write_reg(s.idx, s.val);
			end else begin
				issue_event(s.mode, s.cp, s.gw);
				predict_commands(s.mode, s.cp, s.gw);
				if (s.typed) begin
					if (s.n_typed > 0) begin
						pending_cmds.push_back(s.t0);
					end
					if (s.n_typed > 1) begin
						pending_cmds.push_back(s.t1);
					end
				end else begin
					foreach (predicted_cmds[k]) begin
						pending_cmds.push_back(predicted_cmds[k]);
					end
				end
			end
		end

		for (int ph = 0; ph < 9; ph++) begin
			settle();
			case (ph)
				0: begin
					write_reg(CFG_WIDTH, CFG_DATA_W'($urandom_range(16, 160)));
					write_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(16, 96)));
					write_reg(CFG_SUPPRESS, CFG_DATA_W'(0));
				end
				1: begin
					write_reg(CFG_WIDTH, CFG_DATA_W'(4096));
					write_reg(CFG_HEIGHT, CFG_DATA_W'(4096));
					write_reg(CFG_SUPPRESS, CFG_DATA_W'(0));
				end
				3: begin
					write_reg(CFG_WIDTH, CFG_DATA_W'(16));
					write_reg(CFG_HEIGHT, CFG_DATA_W'(16));
					write_reg(CFG_SUPPRESS, CFG_DATA_W'(0));
				end
				4: begin
					write_reg(CFG_WIDTH, CFG_DATA_W'($urandom_range(0, 8191)));
					write_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(0, 40)));
					write_reg(CFG_SUPPRESS, CFG_DATA_W'($urandom_range(0, 8191) & 13'h1ffe));
				end
				5: begin
					write_reg(CFG_WIDTH, CFG_DATA_W'($urandom_range(16, 80)));
					write_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(16, 64)));
					write_reg(CFG_SUPPRESS, CFG_DATA_W'(1));
				end
				6: begin
					write_reg(CFG_WIDTH, CFG_DATA_W'(15));
					write_reg(CFG_HEIGHT, CFG_DATA_W'(17));
					write_reg(CFG_SUPPRESS, CFG_DATA_W'(0));
				end
				7: begin
					write_reg(CFG_WIDTH, WIDTH_RST);
					write_reg(CFG_HEIGHT, HEIGHT_RST);
					write_reg(CFG_SUPPRESS, CFG_DATA_W'(0));
				end
				default: begin
					write_reg(CFG_WIDTH, CFG_DATA_W'($urandom_range(16, 300)));
					write_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(32, 200)));
					write_reg(CFG_SUPPRESS, CFG_DATA_W'(0));
				end
			endcase
			case (ph % 4)
				0: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct   = 58;
					stall_pct = 0;
				end
				2: begin
					gap_pct   = 0;
					stall_pct = 58;
				end
				default: begin
					gap_pct   = 27;
					stall_pct = 27;
				end
			endcase
			n_items = (ph == 5) ? 80 : 160;
			for (int i = 0; i < n_items; i++) begin
				if (ph % 3 == 1 && i == n_items / 2) begin
					settle();
				end
				make_event(m, cp, gw);
				issue_event(m, cp, gw);
				predict_commands(m, cp, gw);
				foreach (predicted_cmds[k]) begin
					pending_cmds.push_back(predicted_cmds[k]);
				end
			end
		end

		settle();
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
